[design/hbts_pkg.sv]
// Shared types and constants for the histogram threshold search block.
package hbts_pkg;

  localparam int BIN_W       = 11;
  localparam int OUT_CNT_W   = 32;
  localparam int IN_FIELDS_W = 1 + BIN_W;
  localparam int IN_DATA_W   = ((IN_FIELDS_W + 7) / 8) * 8;
  localparam int OUT_FIELDS_W = BIN_W + OUT_CNT_W + OUT_CNT_W + 1;
  localparam int OUT_DATA_W  = ((OUT_FIELDS_W + 7) / 8) * 8;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_LOAD,
    ST_DRAIN,
    ST_START,
    ST_SWEEP,
    ST_FINISH
  } hbts_state_e;

  typedef struct packed {
    logic start;
    logic rd_valid;
    logic rd_last;
  } hbts_sweep_ctl_t;

endpackage

[design/hbts_hist_mem.sv]
// Single histogram store: one write port and one registered read port.
module hbts_hist_mem #(
  parameter int DEPTH  = 1025,
  parameter int DATA_W = 32
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [DATA_W-1:0]        wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [DATA_W-1:0]        rdata_o
);

  logic [DATA_W-1:0] mem [DEPTH];
  logic [DATA_W-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

[design/hbts_sweep.sv]
// Threshold sweep: running class sums, correct count per threshold and best tracking.
module hbts_sweep #(
  parameter int BINS       = 1024,
  parameter int COUNT_BITS = 32
) (
  input  logic                                      clk_i,
  input  logic                                      rst_ni,
  input  hbts_pkg::hbts_sweep_ctl_t                 ctl_i,
  input  logic [COUNT_BITS+$clog2(BINS+2)-1:0]      total1_i,
  input  logic [COUNT_BITS-1:0]                     d0_i,
  input  logic [COUNT_BITS-1:0]                     d1_i,
  input  logic [$clog2(BINS+1)-1:0]                 t_i,
  output logic                                      done_o,
  output logic [$clog2(BINS+1)-1:0]                 best_t_o,
  output logic [COUNT_BITS-1:0]                     best_c_o
);

  import hbts_pkg::*;

  localparam int ADDR_W = $clog2(BINS + 1);
  localparam int SUM_W  = COUNT_BITS + $clog2(BINS + 2);
  localparam logic [COUNT_BITS-1:0] CountMax = {COUNT_BITS{1'b1}};

  logic [SUM_W-1:0]      p0_q, p0_d;
  logic [SUM_W-1:0]      s1_q, s1_d;
  logic [COUNT_BITS-1:0] p0_sat, s1_sat, c_d;
  logic [COUNT_BITS:0]   c_sum;
  logic [COUNT_BITS-1:0] c_q;
  logic [ADDR_W-1:0]     ct_q;
  logic                  cv_q, clast_q;
  logic                  first_q, done_q;
  logic [ADDR_W-1:0]     best_t_q;
  logic [COUNT_BITS-1:0] best_c_q;

  always_comb begin
    p0_sat = (p0_q > SUM_W'(CountMax)) ? CountMax : p0_q[COUNT_BITS-1:0];
    s1_sat = (s1_q > SUM_W'(CountMax)) ? CountMax : s1_q[COUNT_BITS-1:0];
    c_sum  = {1'b0, p0_sat} + {1'b0, s1_sat};
    c_d    = c_sum[COUNT_BITS] ? CountMax : c_sum[COUNT_BITS-1:0];
    p0_d   = p0_q;
    s1_d   = s1_q;
    if (ctl_i.start) begin
      p0_d = '0;
      s1_d = total1_i;
    end else if (ctl_i.rd_valid) begin
      p0_d = p0_q + SUM_W'(d0_i);
      s1_d = s1_q - SUM_W'(d1_i);
    end
  end

  always_ff @(posedge clk_i) begin
    p0_q <= p0_d;
    s1_q <= s1_d;
    c_q  <= c_d;
    ct_q <= t_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cv_q     <= 1'b0;
      clast_q  <= 1'b0;
      first_q  <= 1'b1;
      done_q   <= 1'b0;
      best_t_q <= '0;
      best_c_q <= '0;
    end else begin
      cv_q    <= ctl_i.rd_valid;
      clast_q <= ctl_i.rd_valid & ctl_i.rd_last;
      if (ctl_i.start) begin
        first_q <= 1'b1;
        done_q  <= 1'b0;
      end else if (cv_q) begin
        first_q <= 1'b0;
        if (first_q || (c_q > best_c_q)) begin
          best_t_q <= ct_q;
          best_c_q <= c_q;
        end
        if (clast_q) begin
          done_q <= 1'b1;
        end
      end
    end
  end

  assign done_o   = done_q;
  assign best_t_o = best_t_q;
  assign best_c_o = best_c_q;

endmodule

[design/histogram_best_threshold_search.sv]
// Top level of the histogram threshold search block.
//
// The input stream carries one labelled sample per transaction: tdata holds the
// class label and the quantized score bin, and tlast marks the last sample of a
// data set. While the block is loading, samples are taken one per cycle; a
// histogram update is a read-modify-write on a memory with a registered read
// port and forwarding for repeated bins. After the sample with tlast, the input
// stalls while the block sweeps all BINS+1 thresholds, one memory entry per
// cycle, and clears the histograms in the same pass. The result transaction
// carries the best threshold, its correct count, the sample total and the
// overflow flag. The result sits in an output register, so loading of the next
// data set goes on while the receiver stalls; a new result waits at the end of
// its sweep until the previous one has been taken.
// After reset the block clears both histograms, one entry per cycle; the input
// is not ready during that time.
module histogram_best_threshold_search #(
  parameter int BINS       = 1024,
  parameter int COUNT_BITS = 32
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             s_axis_tvalid,
  output logic                             s_axis_tready,
  // label [0], score_bin [11:1], zero padding above.
  input  logic [hbts_pkg::IN_DATA_W-1:0]   s_axis_tdata,
  input  logic                             s_axis_tlast,
  output logic                             m_axis_tvalid,
  input  logic                             m_axis_tready,
  // best_threshold [10:0], best_correct [42:11], sample_total [74:43],
  // overflow [75], zero padding above.
  output logic [hbts_pkg::OUT_DATA_W-1:0]  m_axis_tdata
);

  import hbts_pkg::*;

  localparam int ADDR_W = $clog2(BINS + 1);
  localparam int SUM_W  = COUNT_BITS + $clog2(BINS + 2);
  localparam logic [COUNT_BITS-1:0] CountMax = {COUNT_BITS{1'b1}};
  localparam logic [ADDR_W-1:0]     LastAddr = ADDR_W'(BINS);

  hbts_state_e state_q, state_d;
  logic [ADDR_W-1:0] addr_q, addr_d;

  logic              in_accept;
  logic              in_label;
  logic [BIN_W-1:0]  in_bin;
  logic [ADDR_W-1:0] in_addr;

  logic              s1_valid_q;
  logic              s1_label_q;
  logic [ADDR_W-1:0] s1_addr_q;
  logic              w_valid_q;
  logic              w_label_q;
  logic [ADDR_W-1:0] w_addr_q;
  logic [COUNT_BITS-1:0] w_data_q;
  logic [COUNT_BITS-1:0] cur_cnt, new_cnt;
  logic              hist_sat;

  logic [COUNT_BITS-1:0] count_q, count_d;
  logic              flag_q, flag_d;
  logic [SUM_W-1:0]  total1_q, total1_d;
  logic [COUNT_BITS-1:0] hold_total_q;
  logic              hold_ovf_q;

  logic              mem_re;
  logic [ADDR_W-1:0] mem_raddr;
  logic              we0, we1;
  logic [ADDR_W-1:0] mem_waddr;
  logic [COUNT_BITS-1:0] mem_wdata;
  logic [COUNT_BITS-1:0] rd0, rd1;

  hbts_sweep_ctl_t   sweep_ctl;
  logic              sweep_rv_q, sweep_rl_q;
  logic [ADDR_W-1:0] sweep_t_q;
  logic              sweep_done;
  logic [ADDR_W-1:0] best_t;
  logic [COUNT_BITS-1:0] best_c;

  logic              out_load;
  logic              m_valid_q;
  logic [OUT_DATA_W-1:0] m_data_q;

  assign in_accept = s_axis_tvalid & s_axis_tready;
  assign in_label  = s_axis_tdata[0];
  assign in_bin    = s_axis_tdata[BIN_W:1];
  assign in_addr   = (32'(in_bin) > 32'(BINS)) ? LastAddr : ADDR_W'(in_bin);

  always_comb begin
    state_d       = state_q;
    addr_d        = addr_q;
    s_axis_tready = 1'b0;
    out_load      = 1'b0;
    sweep_ctl     = '0;
    sweep_ctl.rd_valid = sweep_rv_q;
    sweep_ctl.rd_last  = sweep_rl_q;
    unique case (state_q)
      ST_CLEAR: begin
        addr_d = addr_q + ADDR_W'(1);
        if (addr_q == LastAddr) begin
          addr_d  = '0;
          state_d = ST_LOAD;
        end
      end
      ST_LOAD: begin
        s_axis_tready = 1'b1;
        if (s_axis_tvalid && s_axis_tlast) begin
          state_d = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        state_d = ST_START;
      end
      ST_START: begin
        sweep_ctl.start = 1'b1;
        addr_d  = '0;
        state_d = ST_SWEEP;
      end
      ST_SWEEP: begin
        addr_d = addr_q + ADDR_W'(1);
        if (addr_q == LastAddr) begin
          addr_d  = '0;
          state_d = ST_FINISH;
        end
      end
      ST_FINISH: begin
        if (sweep_done && (!m_valid_q || m_axis_tready)) begin
          out_load = 1'b1;
          state_d  = ST_LOAD;
        end
      end
      default: begin
        state_d = ST_CLEAR;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
      addr_q  <= '0;
    end else begin
      state_q <= state_d;
      addr_q  <= addr_d;
    end
  end

  // Histogram update with forwarding from the write of the previous cycle.
  always_comb begin
    if (w_valid_q && (w_label_q == s1_label_q) && (w_addr_q == s1_addr_q)) begin
      cur_cnt = w_data_q;
    end else begin
      cur_cnt = s1_label_q ? rd1 : rd0;
    end
    hist_sat = (cur_cnt == CountMax);
    new_cnt  = hist_sat ? CountMax : cur_cnt + COUNT_BITS'(1);
  end

  always_comb begin
    mem_re    = in_accept || (state_q == ST_SWEEP);
    mem_raddr = (state_q == ST_SWEEP) ? addr_q : in_addr;
    if (s1_valid_q) begin
      we0       = !s1_label_q;
      we1       = s1_label_q;
      mem_waddr = s1_addr_q;
      mem_wdata = new_cnt;
    end else begin
      we0       = (state_q == ST_CLEAR) || (state_q == ST_SWEEP);
      we1       = we0;
      mem_waddr = addr_q;
      mem_wdata = '0;
    end
  end

  always_comb begin
    count_d  = count_q;
    flag_d   = flag_q;
    total1_d = total1_q;
    if (state_q == ST_START) begin
      count_d  = '0;
      flag_d   = 1'b0;
      total1_d = '0;
    end else begin
      if (in_accept) begin
        if (count_q == CountMax) begin
          flag_d = 1'b1;
        end else begin
          count_d = count_q + COUNT_BITS'(1);
        end
      end
      if (s1_valid_q) begin
        if (hist_sat) begin
          flag_d = 1'b1;
        end else if (s1_label_q) begin
          total1_d = total1_q + SUM_W'(1);
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      w_valid_q  <= 1'b0;
      count_q    <= '0;
      flag_q     <= 1'b0;
      total1_q   <= '0;
      sweep_rv_q <= 1'b0;
      sweep_rl_q <= 1'b0;
      m_valid_q  <= 1'b0;
    end else begin
      s1_valid_q <= in_accept;
      w_valid_q  <= s1_valid_q;
      count_q    <= count_d;
      flag_q     <= flag_d;
      total1_q   <= total1_d;
      sweep_rv_q <= (state_q == ST_SWEEP);
      sweep_rl_q <= (addr_q == LastAddr);
      if (out_load) begin
        m_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        m_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    s1_label_q <= in_label;
    s1_addr_q  <= in_addr;
    w_label_q  <= s1_label_q;
    w_addr_q   <= s1_addr_q;
    w_data_q   <= new_cnt;
    sweep_t_q  <= addr_q;
    if (state_q == ST_START) begin
      hold_total_q <= count_q;
      hold_ovf_q   <= flag_q;
    end
    if (out_load) begin
      m_data_q <= OUT_DATA_W'({hold_ovf_q, OUT_CNT_W'(hold_total_q), OUT_CNT_W'(best_c),
                               BIN_W'(best_t)});
    end
  end

  hbts_hist_mem #(
    .DEPTH  (BINS + 1),
    .DATA_W (COUNT_BITS)
  ) u_hist0 (
    .clk_i   (clk_i),
    .we_i    (we0),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .re_i    (mem_re),
    .raddr_i (mem_raddr),
    .rdata_o (rd0)
  );

  hbts_hist_mem #(
    .DEPTH  (BINS + 1),
    .DATA_W (COUNT_BITS)
  ) u_hist1 (
    .clk_i   (clk_i),
    .we_i    (we1),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .re_i    (mem_re),
    .raddr_i (mem_raddr),
    .rdata_o (rd1)
  );

  hbts_sweep #(
    .BINS       (BINS),
    .COUNT_BITS (COUNT_BITS)
  ) u_sweep (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .ctl_i    (sweep_ctl),
    .total1_i (total1_q),
    .d0_i     (rd0),
    .d1_i     (rd1),
    .t_i      (sweep_t_q),
    .done_o   (sweep_done),
    .best_t_o (best_t),
    .best_c_o (best_c)
  );

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = m_data_q;

endmodule

[design/hbts_checker.sv]
// Port-level checker for the histogram threshold search block and its bind.
module hbts_checker (
  input logic                            clk_i,
  input logic                            rst_ni,
  input logic                            s_axis_tvalid,
  input logic                            s_axis_tready,
  input logic                            s_axis_tlast,
  input logic                            m_axis_tvalid,
  input logic                            m_axis_tready,
  input logic [hbts_pkg::OUT_DATA_W-1:0] m_axis_tdata
);

  // The input stalls for the sweep after the last sample of a data set.
  a_stall_after_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready && s_axis_tlast |=> !s_axis_tready)
    else $error("input ready right after the last sample");

  // A new result only appears at the end of a sweep, when the input was stalled.
  a_result_after_sweep: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid) |-> $past(!s_axis_tready))
    else $error("result appeared while samples were being loaded");

  // The histograms are being cleared when reset is released.
  a_clear_after_reset: assert property (@(posedge clk_i)
    $rose(rst_ni) |-> !s_axis_tready)
    else $error("input ready before the histograms are cleared");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("stalled result changed");

endmodule

bind histogram_best_threshold_search hbts_checker u_hbts_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .s_axis_tlast  (s_axis_tlast),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);
